// ===== sv/hrwa_pkg.sv =====
package hrwa_pkg;

  localparam int WINDOW = 9;
  localparam int IDX_W  = 4;
  localparam int SUM_W  = 12;
  localparam int TIME_W = 32;
  localparam int NUM_W  = 16;
  localparam int DEN_W  = 12;
  localparam int BPM_W  = 8;
  localparam int CFG_W  = 8;

  localparam logic [NUM_W-1:0] RATE_NUMERATOR  = 16'd60000;
  localparam logic [DEN_W-1:0] MIN_INTERVAL_MS = 12'd236;
  localparam logic [DEN_W-1:0] MAX_INTERVAL_MS = 12'd2999;
  localparam logic [SUM_W-1:0] SUM_MAX         = SUM_W'(WINDOW * 255);

  localparam logic [BPM_W-1:0] MIN_AVG_RESET   = 8'd59;
  localparam logic [BPM_W-1:0] MAX_AVG_RESET   = 8'd220;
  localparam logic [BPM_W-1:0] HELD_RESET      = 8'd60;
  localparam logic [BPM_W-1:0] PREV_RESET      = 8'd70;

  typedef enum logic {
    REG_MIN_AVG = 1'b0,
    REG_MAX_AVG = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] diff;
  } sub_res_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_res_t;

endpackage

// ===== sv/hrwa_ser_sub.sv =====
module hrwa_ser_sub (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [hrwa_pkg::TIME_W-1:0] a,
  input  logic [hrwa_pkg::TIME_W-1:0] b,
  output hrwa_pkg::sub_res_t          res
);

  logic [hrwa_pkg::TIME_W-1:0] a_r, a_nxt;
  logic [hrwa_pkg::TIME_W-1:0] b_r, b_nxt;
  logic [hrwa_pkg::TIME_W-1:0] diff_r, diff_nxt;
  logic                        borrow_r, borrow_nxt;
  logic [5:0]                  cnt_r, cnt_nxt;
  logic                        done_r, done_nxt;
  logic                        d_bit;

  // one bit per cycle, lsb first
  assign d_bit = a_r[0] ^ b_r[0] ^ borrow_r;

  always_comb begin
    a_nxt      = a_r;
    b_nxt      = b_r;
    diff_nxt   = diff_r;
    borrow_nxt = borrow_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    if (start) begin
      a_nxt      = a;
      b_nxt      = b;
      borrow_nxt = 1'b0;
      cnt_nxt    = 6'(hrwa_pkg::TIME_W);
    end else if (cnt_r != '0) begin
      a_nxt      = {1'b0, a_r[hrwa_pkg::TIME_W-1:1]};
      b_nxt      = {1'b0, b_r[hrwa_pkg::TIME_W-1:1]};
      diff_nxt   = {d_bit, diff_r[hrwa_pkg::TIME_W-1:1]};
      borrow_nxt = (~a_r[0] & b_r[0]) | (~(a_r[0] ^ b_r[0]) & borrow_r);
      cnt_nxt    = cnt_r - 6'd1;
      done_nxt   = (cnt_r == 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    diff_r   <= diff_nxt;
    borrow_r <= borrow_nxt;
  end

  assign res.done = done_r;
  assign res.diff = diff_r;

endmodule

// ===== sv/hrwa_divider.sv =====
module hrwa_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [hrwa_pkg::NUM_W-1:0] numer,
  input  logic [hrwa_pkg::DEN_W-1:0] denom,
  output hrwa_pkg::div_res_t         res
);

  logic [hrwa_pkg::NUM_W-1:0] quo_r, quo_nxt;
  logic [hrwa_pkg::DEN_W-1:0] rem_r, rem_nxt;
  logic [hrwa_pkg::DEN_W-1:0] den_r, den_nxt;
  logic [4:0]                 cnt_r, cnt_nxt;
  logic                       done_r, done_nxt;
  logic [hrwa_pkg::DEN_W:0]   rem_sh;
  logic [hrwa_pkg::DEN_W:0]   rem_sub;
  logic                       ge;

  // restoring division, one quotient bit per cycle
  assign rem_sh  = {rem_r, quo_r[hrwa_pkg::NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = numer;
      rem_nxt = '0;
      den_nxt = denom;
      cnt_nxt = 5'(hrwa_pkg::NUM_W);
    end else if (cnt_r != '0) begin
      quo_nxt  = {quo_r[hrwa_pkg::NUM_W-2:0], ge};
      rem_nxt  = ge ? rem_sub[hrwa_pkg::DEN_W-1:0] : rem_sh[hrwa_pkg::DEN_W-1:0];
      cnt_nxt  = cnt_r - 5'd1;
      done_nxt = (cnt_r == 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign res.done = done_r;
  assign res.quot = quo_r;

endmodule

// ===== sv/heart_rate_window_average.sv =====
// channel | direction | handshake            | beat payload
// in      | input     | in_valid / in_ready   | in_beat, in_time_ms
// out     | output    | out_valid / out_ready | out_avg_bpm, out_changed, out_report_bpm
// cfg     | input     | cfg_we (no wait)      | cfg_index, cfg_wdata
//
// a sample without a beat passes through S_OUT and loads the result register once the output is free
// a beat first runs the bit-serial interval subtract (32 bits, one per cycle)
// an in-range beat adds two passes of the 16-step shift-subtract divider, for the rate and the mean
// one beat is in flight at a time; the next one is taken once the block is back in idle
// a stalled result sits in the output register while the next beat is accepted
// synchronous active-low reset clears the rate ring, the running sum and all control state
module heart_rate_window_average (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_beat,
  input  logic [hrwa_pkg::TIME_W-1:0] in_time_ms,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hrwa_pkg::BPM_W-1:0]  out_avg_bpm,
  output logic                        out_changed,
  output logic [hrwa_pkg::BPM_W-1:0]  out_report_bpm,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [hrwa_pkg::CFG_W-1:0]  cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_SUB      = 5'b00010,
    S_DIV_RATE = 5'b00100,
    S_DIV_MEAN = 5'b01000,
    S_OUT      = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [hrwa_pkg::BPM_W-1:0]  min_avg_r, max_avg_r;
  logic [hrwa_pkg::TIME_W-1:0] last_beat_r, last_beat_nxt;
  logic [hrwa_pkg::BPM_W-1:0]  held_r, held_nxt;
  logic [hrwa_pkg::BPM_W-1:0]  prev_r, prev_nxt;
  logic [hrwa_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [hrwa_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [hrwa_pkg::BPM_W-1:0]  ring_r [hrwa_pkg::WINDOW];
  logic                        ring_we;
  logic [hrwa_pkg::BPM_W-1:0]  rate;
  logic [hrwa_pkg::BPM_W-1:0]  mean;
  logic [hrwa_pkg::SUM_W-1:0]  sum_upd;

  logic                        out_valid_r, out_valid_nxt;
  logic [hrwa_pkg::BPM_W-1:0]  out_avg_r, out_avg_nxt;
  logic                        out_chg_r, out_chg_nxt;
  logic [hrwa_pkg::BPM_W-1:0]  out_rep_r, out_rep_nxt;
  logic [hrwa_pkg::BPM_W:0]    pair_sum;

  logic                        in_acc, out_free, in_range;
  logic                        sub_start, div_start;
  logic [hrwa_pkg::NUM_W-1:0]  div_numer;
  logic [hrwa_pkg::DEN_W-1:0]  div_denom;
  hrwa_pkg::sub_res_t          sub_res;
  hrwa_pkg::div_res_t          div_res;

  hrwa_ser_sub u_sub (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sub_start),
    .a     (in_time_ms),
    .b     (last_beat_r),
    .res   (sub_res)
  );

  hrwa_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .res   (div_res)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;

  assign in_range = (sub_res.diff[hrwa_pkg::TIME_W-1:hrwa_pkg::DEN_W] == '0) &&
                    (sub_res.diff[hrwa_pkg::DEN_W-1:0] >= hrwa_pkg::MIN_INTERVAL_MS) &&
                    (sub_res.diff[hrwa_pkg::DEN_W-1:0] <= hrwa_pkg::MAX_INTERVAL_MS);

  assign rate     = div_res.quot[hrwa_pkg::BPM_W-1:0];
  assign mean     = div_res.quot[hrwa_pkg::BPM_W-1:0];
  // running sum replaces the oldest rate with the new one
  assign sum_upd  = sum_r - hrwa_pkg::SUM_W'(ring_r[idx_r]) + hrwa_pkg::SUM_W'(rate);
  assign pair_sum = {1'b0, held_r} + {1'b0, prev_r};

  always_comb begin
    state_nxt     = state_r;
    last_beat_nxt = last_beat_r;
    held_nxt      = held_r;
    prev_nxt      = prev_r;
    sum_nxt       = sum_r;
    idx_nxt       = idx_r;
    ring_we       = 1'b0;
    sub_start     = 1'b0;
    div_start     = 1'b0;
    div_numer     = hrwa_pkg::RATE_NUMERATOR;
    div_denom     = sub_res.diff[hrwa_pkg::DEN_W-1:0];
    out_valid_nxt = out_valid_r & ~out_ready;
    out_avg_nxt   = out_avg_r;
    out_chg_nxt   = out_chg_r;
    out_rep_nxt   = out_rep_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_beat) begin
            sub_start     = 1'b1;
            last_beat_nxt = in_time_ms;
            state_nxt     = S_SUB;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_SUB: begin
        if (sub_res.done) begin
          if (in_range) begin
            div_start = 1'b1;
            state_nxt = S_DIV_RATE;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_DIV_RATE: begin
        if (div_res.done) begin
          ring_we   = 1'b1;
          sum_nxt   = sum_upd;
          idx_nxt   = (idx_r == hrwa_pkg::IDX_W'(hrwa_pkg::WINDOW - 1)) ? '0 : idx_r + 1'b1;
          div_start = 1'b1;
          div_numer = hrwa_pkg::NUM_W'(sum_upd);
          div_denom = hrwa_pkg::DEN_W'(hrwa_pkg::WINDOW);
          state_nxt = S_DIV_MEAN;
        end
      end
      S_DIV_MEAN: begin
        div_denom = hrwa_pkg::DEN_W'(hrwa_pkg::WINDOW);
        if (div_res.done) begin
          if (mean >= min_avg_r && mean <= max_avg_r) begin
            held_nxt = mean;
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = held_r;
          out_chg_nxt   = (held_r != prev_r);
          out_rep_nxt   = pair_sum[hrwa_pkg::BPM_W:1];
          prev_nxt      = held_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_avg_r   <= hrwa_pkg::MIN_AVG_RESET;
      max_avg_r   <= hrwa_pkg::MAX_AVG_RESET;
      last_beat_r <= '0;
      held_r      <= hrwa_pkg::HELD_RESET;
      prev_r      <= hrwa_pkg::PREV_RESET;
      sum_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < hrwa_pkg::WINDOW; k++) begin
        ring_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      last_beat_r <= last_beat_nxt;
      held_r      <= held_nxt;
      prev_r      <= prev_nxt;
      sum_r       <= sum_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (ring_we) begin
        ring_r[idx_r] <= rate;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          hrwa_pkg::REG_MIN_AVG: min_avg_r <= cfg_wdata;
          hrwa_pkg::REG_MAX_AVG: max_avg_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    out_avg_r <= out_avg_nxt;
    out_chg_r <= out_chg_nxt;
    out_rep_r <= out_rep_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_avg_bpm    = out_avg_r;
  assign out_changed    = out_chg_r;
  assign out_report_bpm = out_rep_r;

  a_same_avg_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_changed |-> out_report_bpm == out_avg_bpm)
    else $error("report differs from an unchanged average");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= hrwa_pkg::SUM_MAX)
    else $error("running rate sum out of range");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r < hrwa_pkg::IDX_W'(hrwa_pkg::WINDOW))
    else $error("ring index past window");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && out_free |=> out_valid && in_ready)
    else $error("finished beat did not reach the output register");

endmodule
